// ===== hdl/sau_pkg.sv =====
// Shared types and constants of the stack arithmetic unit.
// Depends on nothing.
package sau_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned DEPTH_OUT_W = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH = 3'd0,
    KIND_SWAP = 3'd1,
    KIND_DIV  = 3'd2,
    KIND_MUL  = 3'd3,
    KIND_MOD  = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_SHORT   = 2'd1,
    STAT_DIVZERO = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic    load;
    logic    push;
    logic    mem_rd;
    logic    swap;
    logic    mul_start;
    logic    mul_write;
    logic    div_start;
    logic    div_write;
    logic    div_mod;
    logic    out_load;
    status_e status;
  } sau_cmd_t;

  typedef struct packed {
    logic full;
    logic ge2;
    logic top_zero;
    logic div_done;
  } sau_stat_t;

endpackage

// ===== hdl/sau_req_if.sv =====
// Request channel of the stack arithmetic unit: valid/ready with operation payload.
// Depends on nothing.
interface sau_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic signed [31:0] push_value;

  modport source (output valid, kind, push_value, input ready);
  modport sink   (input valid, kind, push_value, output ready);
endinterface

// ===== hdl/sau_rsp_if.sv =====
// Response channel of the stack arithmetic unit: valid/ready with result payload.
// Depends on nothing.
interface sau_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] top_value;
  logic [6:0]         stack_depth;

  modport source (output valid, status, top_value, stack_depth, input ready);
  modport sink   (input valid, status, top_value, stack_depth, output ready);
endinterface

// ===== hdl/stack_arith_unit_top.sv =====
// Top level of the stack arithmetic unit: controller plus datapath.
// Depends on sau_pkg, sau_req_if, sau_rsp_if, sau_ctrl and sau_dp.
//
//   channel  dir  payload                               handshake
//   req_i    in   kind, push_value                      valid/ready
//   rsp_o    out  status, top_value, stack_depth        valid/ready
//
// One transaction at a time. Push, unused kinds and every error pass through decode and
// done; swap adds a read state, multiply a read and a multiply state, and divide or
// modulo a read state and then the divide state, where the divider retires one quotient
// bit per cycle. The next request is taken once the result is in the output register.
// A new request is taken while the previous response waits in the output register.
// Reset empties the stack; stack memory contents are not cleared.
module stack_arith_unit_top #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  sau_req_if.sink   req_i,
  sau_rsp_if.source rsp_o
);
  import sau_pkg::*;

  sau_cmd_t          cmd;
  sau_stat_t         stat;
  logic [WORD_W-1:0] top_value;

  sau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_kind_i  (req_i.kind),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sau_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .push_value_i  (req_i.push_value),
    .status_o      (rsp_o.status),
    .top_value_o   (top_value),
    .stack_depth_o (rsp_o.stack_depth)
  );

  assign rsp_o.top_value = top_value;

endmodule

// ===== hdl/sau_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on sau_pkg.
module sau_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sau_pkg::WORD_W-1:0] dividend_i,
  input  logic [sau_pkg::WORD_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [sau_pkg::WORD_W-1:0] quot_o,
  output logic [sau_pkg::WORD_W-1:0] rem_o
);
  import sau_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_W);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WORD_W-1:0] rem_q, rem_d;
  logic [WORD_W-1:0] quo_q, quo_d;
  logic [WORD_W-1:0] den_q, den_d;
  logic              qneg_q, qneg_d;
  logic              rneg_q, rneg_d;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   trial;

  always_comb begin
    shifted = {rem_q, quo_q[WORD_W-1]};
    trial   = shifted - {1'b0, den_q};
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    qneg_d  = qneg_q;
    rneg_d  = rneg_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i[WORD_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      den_d  = divisor_i[WORD_W-1] ? (~divisor_i + 1'b1) : divisor_i;
      qneg_d = dividend_i[WORD_W-1] ^ divisor_i[WORD_W-1];
      rneg_d = dividend_i[WORD_W-1];
    end else if (run_q) begin
      if (!trial[WORD_W]) begin
        rem_d = trial[WORD_W-1:0];
        quo_d = {quo_q[WORD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[WORD_W-1:0];
        quo_d = {quo_q[WORD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(WORD_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
  end

  assign done_o = done_q;
  assign quot_o = qneg_q ? (~quo_q + 1'b1) : quo_q;
  assign rem_o  = rneg_q ? (~rem_q + 1'b1) : rem_q;

endmodule

// ===== hdl/sau_ctrl.sv =====
// Controller of the stack arithmetic unit: sequences each operation and the response.
// Depends on sau_pkg.
module sau_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  logic [2:0]          req_kind_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  input  sau_pkg::sau_stat_t  stat_i,
  output sau_pkg::sau_cmd_t   cmd_o
);
  import sau_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_READ   = 6'b000100,
    ST_MUL    = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  state_e  state_q, state_d;
  kind_e   kind_q, kind_d;
  status_e status_q, status_d;
  logic    out_valid_q, out_valid_d;
  logic    is_divmod;

  assign is_divmod = (kind_q == KIND_DIV) || (kind_q == KIND_MOD);

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    status_d = status_q;
    cmd_o    = '0;
    cmd_o.status  = status_q;
    cmd_o.div_mod = (kind_q == KIND_MOD);
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          kind_d     = kind_e'(req_kind_i);
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        status_d = STAT_OK;
        state_d  = ST_DONE;
        case (kind_q)
          KIND_PUSH: begin
            if (stat_i.full) begin
              status_d = STAT_FULL;
            end else begin
              cmd_o.push = 1'b1;
            end
          end
          KIND_SWAP, KIND_DIV, KIND_MUL, KIND_MOD: begin
            if (!stat_i.ge2) begin
              status_d = STAT_SHORT;
            end else if (is_divmod && stat_i.top_zero) begin
              status_d = STAT_DIVZERO;
            end else begin
              cmd_o.mem_rd = 1'b1;
              state_d      = ST_READ;
            end
          end
          default: begin
            status_d = STAT_OK;
          end
        endcase
      end
      ST_READ: begin
        case (kind_q)
          KIND_SWAP: begin
            cmd_o.swap = 1'b1;
            state_d    = ST_DONE;
          end
          KIND_MUL: begin
            cmd_o.mul_start = 1'b1;
            state_d         = ST_MUL;
          end
          KIND_DIV, KIND_MOD: begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_MUL: begin
        cmd_o.mul_write = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.div_write = 1'b1;
          state_d         = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= KIND_PUSH;
      status_q    <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule

// ===== hdl/sau_dp.sv =====
// Datapath of the stack arithmetic unit: stack memory, cached top, depth, multiplier,
// divider and response register. Depends on sau_pkg and sau_div.
module sau_dp #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sau_pkg::sau_cmd_t               cmd_i,
  output sau_pkg::sau_stat_t              stat_o,
  input  logic [sau_pkg::WORD_W-1:0]      push_value_i,
  output logic [sau_pkg::STAT_W-1:0]      status_o,
  output logic [sau_pkg::WORD_W-1:0]      top_value_o,
  output logic [sau_pkg::DEPTH_OUT_W-1:0] stack_depth_o
);
  import sau_pkg::*;

  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic [WORD_W-1:0]   mem [STACK_DEPTH];
  logic [WORD_W-1:0]   pv_q;
  logic [WORD_W-1:0]   top_q, top_d;
  logic [DW-1:0]       depth_q, depth_d;
  logic [WORD_W-1:0]   rd_q;
  logic [WORD_W-1:0]   prod_q;
  logic [WORD_W-1:0]   prod_full;
  logic [DW-1:0]       idx_top;
  logic [DW-1:0]       idx_sec;
  logic [AW-1:0]       wr_addr;
  logic                wr_en;
  logic                div_done;
  logic [WORD_W-1:0]   div_quot;
  logic [WORD_W-1:0]   div_rem;
  logic [DW+DEPTH_OUT_W-1:0] depth_ext;

  assign idx_top = depth_q - 1'b1;
  assign idx_sec = depth_q - DW'(2);
  assign wr_en   = (cmd_i.push && (depth_q != '0)) || cmd_i.swap;
  assign wr_addr = cmd_i.push ? idx_top[AW-1:0] : idx_sec[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= top_q;
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem[idx_sec[AW-1:0]];
    end
  end

  assign prod_full = rd_q * top_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pv_q <= push_value_i;
    end
    if (cmd_i.mul_start) begin
      prod_q <= prod_full;
    end
    top_q <= top_d;
  end

  sau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rd_q),
    .divisor_i  (top_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    top_d   = top_q;
    depth_d = depth_q;
    if (cmd_i.push) begin
      top_d   = pv_q;
      depth_d = depth_q + 1'b1;
    end else if (cmd_i.swap) begin
      top_d = rd_q;
    end else if (cmd_i.mul_write) begin
      top_d   = prod_q;
      depth_d = depth_q - 1'b1;
    end else if (cmd_i.div_write) begin
      top_d   = cmd_i.div_mod ? div_rem : div_quot;
      depth_d = depth_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  assign depth_ext = {{DEPTH_OUT_W{1'b0}}, depth_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o      <= cmd_i.status;
      top_value_o   <= (depth_q != '0) ? top_q : '0;
      stack_depth_o <= depth_ext[DEPTH_OUT_W-1:0];
    end
  end

  assign stat_o.full     = (depth_q == DW'(STACK_DEPTH));
  assign stat_o.ge2      = (depth_q >= DW'(2));
  assign stat_o.top_zero = (top_q == '0);
  assign stat_o.div_done = div_done;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for stack_arith_unit_top: directed and random stack operations.
// A scoreboard class predicts every response; depends on sau_pkg, sau_req_if and sau_rsp_if.
module tb;
  import sau_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam logic [KIND_W-1:0] KIND_NOP_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_NOP_HI = 3'd7;
  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] WORD_NEG1 = 32'hffff_ffff;

  typedef struct {
    status_e                status;
    logic [WORD_W-1:0]      top;
    logic [DEPTH_OUT_W-1:0] depth;
  } stack_result_t;

  class stack_scoreboard;
    logic [WORD_W-1:0] words [DEPTH];
    int unsigned       depth;
    stack_result_t     result_q[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       status_seen [4];

    function void note_request(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] value);
      stack_result_t     res;
      longint            num;
      longint            den;
      logic [WORD_W-1:0] tmp;
      res.status = STAT_OK;
      if (kind == KIND_PUSH) begin
        if (depth >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          words[depth] = value;
          depth++;
        end
      end else if (kind <= KIND_MOD) begin
        if (depth < 2) begin
          res.status = STAT_SHORT;
        end else begin
          num = $signed(words[depth-2]);
          den = $signed(words[depth-1]);
          case (kind)
            KIND_SWAP: begin
              tmp = words[depth-1];
              words[depth-1] = words[depth-2];
              words[depth-2] = tmp;
            end
            KIND_MUL: begin
              words[depth-2] = words[depth-2] * words[depth-1];
              depth--;
            end
            default: begin
              if (den == 0) begin
                res.status = STAT_DIVZERO;
              end else begin
                words[depth-2] = (kind == KIND_DIV) ? 32'(num / den) : 32'(num % den);
                depth--;
              end
            end
          endcase
        end
      end
      res.top = (depth > 0) ? words[depth-1] : '0;
      res.depth = 7'(depth);
      result_q.push_back(res);
    endfunction

    function void check_response(logic [STAT_W-1:0] status, logic [WORD_W-1:0] top,
                                 logic [DEPTH_OUT_W-1:0] dep);
      stack_result_t exp;
      if (result_q.size() == 0) begin
        $error("unexpected response: status %0d top %0d depth %0d", status, $signed(top), dep);
        errors++;
        return;
      end
      exp = result_q.pop_front();
      checked++;
      status_seen[exp.status]++;
      if (status !== exp.status) begin
        $error("status: expected %0d actual %0d", exp.status, status);
        errors++;
      end
      if (top !== exp.top) begin
        $error("top_value: expected %0d actual %0d", $signed(exp.top), $signed(top));
        errors++;
      end
      if (dep !== exp.depth) begin
        $error("stack_depth: expected %0d actual %0d", exp.depth, dep);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return result_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet;
  bit   hold_rsp_req;
  int unsigned cycles;

  stack_scoreboard sb = new();

  sau_req_if req ();
  sau_rsp_if rsp ();

  stack_arith_unit_top #(
    .STACK_DEPTH(DEPTH)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp.valid && rsp.ready) begin
      sb.check_response(rsp.status, rsp.top_value, rsp.stack_depth);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WORD_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 14) return 32'd1;
    if (r < 20) return WORD_NEG1;
    if (r < 25) return WORD_MIN;
    if (r < 30) return WORD_MAX;
    if (r < 60) return 32'($urandom_range(0, 200)) - 32'd100;
    return $urandom();
  endfunction

  function automatic logic [KIND_W-1:0] KIND_KIND_ARITH();
    int unsigned r;
    r = $urandom_range(0, 59);
    if (r < 10) return KIND_SWAP;
    if (r < 30) return KIND_DIV;
    if (r < 42) return KIND_MUL;
    return KIND_MOD;
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int unsigned r;
    int unsigned push_pct;
    r = $urandom_range(0, 99);
    if (sb.depth < 2) begin
      return (r < 90) ? KIND_PUSH : KIND_KIND_ARITH();
    end
    push_pct = (sb.depth > 12) ? 10 : 40;
    if (r < push_pct) return KIND_PUSH;
    return KIND_KIND_ARITH();
  endfunction

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value);
    int unsigned gap;
    req.valid <= 1'b1;
    req.kind <= kind;
    req.push_value <= value;
    do @(posedge clk); while (!req.ready);
    sb.note_request(kind, value);
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned stall;
    stall = 0;
    rsp.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall == 0 && hold_rsp_req) begin
        hold_rsp_req = 1'b0;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && !quiet && $urandom_range(0, 99) < 20) begin
        stall = pick_gap() + 1;
      end
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        stall--;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned       random_sent;
    int unsigned       roll;
    logic [KIND_W-1:0] kind;
    bit                held;
    bit                paused;
    random_sent = 0;
    held = 1'b0;
    paused = 1'b0;
    cycles = 0;
    quiet = 1'b0;
    hold_rsp_req = 1'b0;
    req.valid = 1'b0;
    req.kind = KIND_PUSH;
    req.push_value = '0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(KIND_SWAP, '0);
    send_request(KIND_DIV, WORD_MAX);
    send_request(KIND_PUSH, WORD_MIN);
    send_request(KIND_MUL, '0);
    send_request(KIND_MOD, WORD_NEG1);
    send_request(KIND_PUSH, WORD_NEG1);
    send_request(KIND_DIV, '0);
    send_request(KIND_PUSH, WORD_NEG1);
    send_request(KIND_MOD, '0);
    send_request(KIND_PUSH, '0);
    send_request(KIND_DIV, '0);
    send_request(KIND_MOD, '0);
    send_request(KIND_SWAP, '0);
    send_request(KIND_PUSH, WORD_MAX);
    send_request(KIND_PUSH, WORD_MAX);
    send_request(KIND_MUL, '0);
    send_request(KIND_PUSH, -32'sd7);
    send_request(KIND_PUSH, 32'd2);
    send_request(KIND_DIV, '0);
    send_request(KIND_PUSH, 32'd2);
    send_request(KIND_MOD, '0);
    for (int k = KIND_NOP_LO; k <= KIND_NOP_HI; k++) begin
      send_request(3'(k), $urandom());
    end
    send_request(KIND_SWAP, WORD_MIN);

    while (random_sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 999);
      if (roll < 4) begin
        while (sb.depth < DEPTH) begin
          send_request(KIND_PUSH, pick_value());
          random_sent++;
        end
        repeat ($urandom_range(1, 2)) begin
          send_request(KIND_PUSH, pick_value());
          random_sent++;
        end
      end else if (roll < 900) begin
        send_request(pick_kind(), pick_value());
        random_sent++;
      end else begin
        kind = 3'($urandom_range(0, 7));
        send_request(kind, $urandom());
        if (kind <= KIND_MOD) random_sent++;
      end
      quiet = (random_sent >= 300 && random_sent < 420) ||
              (random_sent >= 1400 && random_sent < 1500);
      if (!held && random_sent >= 600) begin
        held = 1'b1;
        hold_rsp_req = 1'b1;
      end
      if (!paused && random_sent >= 1100) begin
        paused = 1'b1;
        req.valid <= 1'b0;
        wait_drained();
      end
    end
    req.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d responses checked over push, swap, divide, multiply, modulo, no-op",
             sb.checked);
    $display("summary: ok %0d, short stack %0d, divide by zero %0d, stack full %0d",
             sb.status_seen[STAT_OK], sb.status_seen[STAT_SHORT],
             sb.status_seen[STAT_DIVZERO], sb.status_seen[STAT_FULL]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sau_pkg.sv
hdl/sau_req_if.sv
hdl/sau_rsp_if.sv
hdl/sau_div.sv
hdl/sau_ctrl.sv
hdl/sau_dp.sv
hdl/stack_arith_unit_top.sv
bench/tb.sv
